>>> design/bst_pkg.sv
package bst_pkg;

	// Build defaults
	localparam int MAX_DEPTH_DEF = 32;
	localparam int LEN_BITS_DEF  = 32;

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 64;
	localparam int NEST_W  = 6;
	localparam int EV_W    = 3;
	localparam int ERR_W   = 3;
	localparam int KIND_W  = 2;

	// Event codes
	localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EV_W-1:0] EV_INT     = 3'd1;
	localparam logic [EV_W-1:0] EV_STRHDR  = 3'd2;
	localparam logic [EV_W-1:0] EV_STRBYTE = 3'd3;
	localparam logic [EV_W-1:0] EV_LOPEN   = 3'd4;
	localparam logic [EV_W-1:0] EV_DOPEN   = 3'd5;
	localparam logic [EV_W-1:0] EV_CLOSE   = 3'd6;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
	localparam logic [ERR_W-1:0] ERR_TYPE    = 3'd1;
	localparam logic [ERR_W-1:0] ERR_INT_END = 3'd2;
	localparam logic [ERR_W-1:0] ERR_COLON   = 3'd3;
	localparam logic [ERR_W-1:0] ERR_OVERRUN = 3'd4;
	localparam logic [ERR_W-1:0] ERR_KEY     = 3'd5;
	localparam logic [ERR_W-1:0] ERR_EARLY   = 3'd6;
	localparam logic [ERR_W-1:0] ERR_DEEP    = 3'd7;

	// Container kinds held on the stack
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LIST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DKEY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DVAL = 2'd3;

	// Characters
	localparam logic [BYTE_W-1:0] CH_I     = 8'h69;
	localparam logic [BYTE_W-1:0] CH_L     = 8'h6c;
	localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
	localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;

	typedef enum logic [7:0] {
		PH_EXPECT     = 8'b0000_0001,
		PH_INT_START  = 8'b0000_0010,
		PH_INT_WS     = 8'b0000_0100,
		PH_INT_SIGN   = 8'b0000_1000,
		PH_INT_DIGITS = 8'b0001_0000,
		PH_STR_LEN    = 8'b0010_0000,
		PH_STR_BYTES  = 8'b0100_0000,
		PH_DONE       = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [EV_W-1:0]           event_res;
		logic signed [VALUE_W-1:0] value;
		logic [BYTE_W-1:0]         data_byte;
		logic [NEST_W-1:0]         nest_depth;
		logic                      done_res;
		logic [ERR_W-1:0]          error_code;
	} res_t;

endpackage

>>> design/bst_ram.sv
module bst_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> design/bst_out_buf.sv
module bst_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bst_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output bst_pkg::res_t out_data
);

	logic          out_v_q;
	logic          skid_v_q;
	bst_pkg::res_t out_q;
	bst_pkg::res_t skid_q;
	logic          slot_free;

	// output register can take new data this cycle
	assign slot_free = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (slot_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

endmodule

>>> design/bencode_stream_tokenizer_core.sv
// Bencode stream tokenizer.
// Input channel: in_byte/message_end with in_valid/in_stall; one byte per transaction,
// message_end set on the last byte of a message buffer.
// Output channel: one result transaction per input byte (event_res, value, data_byte,
// nest_depth, done_res, error_code) with out_valid/out_stall.
// Throughput: one byte per cycle sustained while in_stall is low. Each byte is parsed in
// the cycle it is accepted; its result is registered in the output register, or in the
// skid entry while that register is stalled. The open-container stack lives in a RAM
// with a registered read; the top entry is held in a register and the RAM is always
// pre-reading the entry below it, bypassing last cycle's push write; pops never wait.
// Stall: results queue in the output register plus one skid entry; in_stall is
// raised only while the skid entry is occupied, so the input keeps flowing while a
// single result waits to be taken.
// Reset (arst_n low): both buffers empty, parser expecting a top-level value, depth
// zero, no error. Stack RAM contents are not cleared and need no clearing pass; only
// entries pushed since are read. After any byte with message_end the parser returns
// to that same state for the next message.
// Errors are sticky: the failing byte and later bytes report the code with no event
// until message_end.
module bencode_stream_tokenizer_core #(
	parameter int MAX_DEPTH = bst_pkg::MAX_DEPTH_DEF,
	parameter int LEN_BITS  = bst_pkg::LEN_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bst_pkg::BYTE_W-1:0]          in_byte,
	input  logic                                message_end,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bst_pkg::EV_W-1:0]            event_res,
	output logic signed [bst_pkg::VALUE_W-1:0]  value,
	output logic [bst_pkg::BYTE_W-1:0]          data_byte,
	output logic [bst_pkg::NEST_W-1:0]          nest_depth,
	output logic                                done_res,
	output logic [bst_pkg::ERR_W-1:0]           error_code
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int VW = bst_pkg::VALUE_W;
	localparam int KW = bst_pkg::KIND_W;
	localparam logic [VW-1:0] LEN_CAP = VW'((65'd1 << LEN_BITS) - 65'd1);
	localparam logic [VW-1:0] INT_POS_CAP = {1'b0, {(VW-1){1'b1}}};
	localparam logic [VW-1:0] INT_NEG_CAP = {1'b1, {(VW-1){1'b0}}};

	// state
	bst_pkg::phase_t      phase_q;
	logic [VW-1:0]        accum_q;
	logic                 neg_q;
	logic [LEN_BITS-1:0]  bytes_q;
	logic [DW-1:0]        depth_q;
	logic [KW-1:0]        top_q;
	logic [bst_pkg::ERR_W-1:0] sticky_q;
	logic                 fwd_q;
	logic [KW-1:0]        fwd_data_q;

	// next state
	bst_pkg::phase_t      phase_n;
	logic [VW-1:0]        accum_n;
	logic                 neg_n;
	logic [LEN_BITS-1:0]  bytes_n;
	logic [DW-1:0]        depth_a;
	logic [DW-1:0]        depth_n;
	logic [KW-1:0]        top_n;

	logic                 in_fire;
	logic                 is_digit;
	logic                 is_ws;
	logic [3:0]           digit;
	logic [KW-1:0]        top_kind;
	logic [KW-1:0]        below;
	logic [KW-1:0]        rd_data;
	logic [KW-1:0]        push_kind;
	logic                 push;
	logic                 pop;
	logic                 fin;
	logic [VW-1:0]        sat_cap;
	logic [VW+3:0]        sat_sum;
	logic [VW-1:0]        sat_val;
	logic [bst_pkg::ERR_W-1:0] err;
	bst_pkg::res_t        res;
	bst_pkg::res_t        res_out;

	function automatic logic [bst_pkg::KIND_W-1:0] toggle_kind(
		input logic [bst_pkg::KIND_W-1:0] k
	);
		logic [bst_pkg::KIND_W-1:0] r;
		r = k;
		if (k == bst_pkg::KIND_DKEY) begin
			r = bst_pkg::KIND_DVAL;
		end else if (k == bst_pkg::KIND_DVAL) begin
			r = bst_pkg::KIND_DKEY;
		end
		return r;
	endfunction

	assign in_fire  = in_valid && !in_stall;
	assign is_digit = (in_byte >= bst_pkg::CH_0) && (in_byte <= bst_pkg::CH_9);
	assign is_ws    = (in_byte == bst_pkg::CH_SPACE) ||
		((in_byte >= bst_pkg::CH_TAB) && (in_byte <= bst_pkg::CH_CR));
	assign digit    = 4'(in_byte - bst_pkg::CH_0);
	assign top_kind = (depth_q != '0) ? top_q : bst_pkg::KIND_NONE;
	// entry below the top: bypass the write made by last cycle's push
	assign below    = fwd_q ? fwd_data_q : rd_data;

	// shared saturating decimal step: acc*10 + d, clamped to cap
	always_comb begin
		if (phase_q == bst_pkg::PH_STR_LEN) begin
			sat_cap = LEN_CAP;
		end else if (neg_q) begin
			sat_cap = INT_NEG_CAP;
		end else begin
			sat_cap = INT_POS_CAP;
		end
		sat_sum = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + (VW+4)'(digit);
		sat_val = (sat_sum > {4'b0, sat_cap}) ? sat_cap : sat_sum[VW-1:0];
	end

	always_comb begin
		res.event_res = bst_pkg::EV_NONE;
		res.value     = '0;
		res.data_byte = '0;
		res.done_res  = 1'b0;
		err       = bst_pkg::ERR_OK;
		phase_n   = phase_q;
		accum_n   = accum_q;
		neg_n     = neg_q;
		bytes_n   = bytes_q;
		top_n     = top_q;
		push      = 1'b0;
		pop       = 1'b0;
		fin       = 1'b0;
		push_kind = bst_pkg::KIND_LIST;

		if (sticky_q == bst_pkg::ERR_OK) begin
			case (phase_q)
				bst_pkg::PH_EXPECT: begin
					if (in_byte == bst_pkg::CH_E && (top_kind == bst_pkg::KIND_LIST ||
						top_kind == bst_pkg::KIND_DKEY)) begin
						pop           = 1'b1;
						res.event_res = bst_pkg::EV_CLOSE;
					end else if (top_kind == bst_pkg::KIND_DKEY &&
						(in_byte == bst_pkg::CH_I || in_byte == bst_pkg::CH_L ||
						in_byte == bst_pkg::CH_D)) begin
						err = bst_pkg::ERR_KEY;
					end else if (in_byte == bst_pkg::CH_I) begin
						accum_n = '0;
						neg_n   = 1'b0;
						phase_n = bst_pkg::PH_INT_START;
					end else if (in_byte == bst_pkg::CH_L || in_byte == bst_pkg::CH_D) begin
						if (depth_q >= DW'(MAX_DEPTH)) begin
							err = bst_pkg::ERR_DEEP;
						end else begin
							push = 1'b1;
							if (in_byte == bst_pkg::CH_L) begin
								push_kind     = bst_pkg::KIND_LIST;
								res.event_res = bst_pkg::EV_LOPEN;
							end else begin
								push_kind     = bst_pkg::KIND_DKEY;
								res.event_res = bst_pkg::EV_DOPEN;
							end
						end
					end else if (is_digit) begin
						accum_n = VW'(digit);
						phase_n = bst_pkg::PH_STR_LEN;
					end else begin
						err = bst_pkg::ERR_TYPE;
					end
				end
				bst_pkg::PH_INT_START, bst_pkg::PH_INT_WS: begin
					if (phase_q == bst_pkg::PH_INT_START && in_byte == bst_pkg::CH_E) begin
						res.event_res = bst_pkg::EV_INT;
						fin           = 1'b1;
					end else if (is_ws) begin
						phase_n = bst_pkg::PH_INT_WS;
					end else if (in_byte == bst_pkg::CH_PLUS || in_byte == bst_pkg::CH_MINUS) begin
						neg_n   = (in_byte == bst_pkg::CH_MINUS);
						phase_n = bst_pkg::PH_INT_SIGN;
					end else if (is_digit) begin
						accum_n = sat_val;
						phase_n = bst_pkg::PH_INT_DIGITS;
					end else begin
						err = bst_pkg::ERR_INT_END;
					end
				end
				bst_pkg::PH_INT_SIGN: begin
					if (is_digit) begin
						accum_n = sat_val;
						phase_n = bst_pkg::PH_INT_DIGITS;
					end else begin
						err = bst_pkg::ERR_INT_END;
					end
				end
				bst_pkg::PH_INT_DIGITS: begin
					if (is_digit) begin
						accum_n = sat_val;
					end else if (in_byte == bst_pkg::CH_E) begin
						res.event_res = bst_pkg::EV_INT;
						res.value     = neg_q ? (VW'(0) - accum_q) : accum_q;
						fin           = 1'b1;
					end else begin
						err = bst_pkg::ERR_INT_END;
					end
				end
				bst_pkg::PH_STR_LEN: begin
					if (is_digit) begin
						accum_n = sat_val;
					end else if (in_byte == bst_pkg::CH_COLON) begin
						res.event_res = bst_pkg::EV_STRHDR;
						res.value     = accum_q;
						bytes_n       = LEN_BITS'(accum_q);
						if (accum_q == '0) begin
							fin = 1'b1;
						end else begin
							phase_n = bst_pkg::PH_STR_BYTES;
						end
					end else begin
						err = bst_pkg::ERR_COLON;
					end
				end
				bst_pkg::PH_STR_BYTES: begin
					res.event_res = bst_pkg::EV_STRBYTE;
					res.data_byte = in_byte;
					bytes_n       = bytes_q - LEN_BITS'(1);
					if (bytes_q == LEN_BITS'(1)) begin
						fin = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// stack depth and top-of-stack update
		depth_a = depth_q;
		if (pop) begin
			depth_a = depth_q - DW'(1);
		end else if (push) begin
			depth_a = depth_q + DW'(1);
			top_n   = push_kind;
		end
		if (pop || fin) begin
			if (depth_a == '0) begin
				phase_n = bst_pkg::PH_DONE;
			end else begin
				top_n   = toggle_kind(pop ? below : top_q);
				phase_n = bst_pkg::PH_EXPECT;
			end
		end

		// status
		res.error_code = sticky_q;
		if (sticky_q == bst_pkg::ERR_OK) begin
			if (err != bst_pkg::ERR_OK) begin
				res.error_code = err;
			end else if (message_end) begin
				if (phase_n == bst_pkg::PH_DONE) begin
					res.done_res = 1'b1;
				end else if (phase_n == bst_pkg::PH_STR_BYTES) begin
					res.error_code = bst_pkg::ERR_OVERRUN;
				end else begin
					res.error_code = bst_pkg::ERR_EARLY;
				end
			end
		end
		res.nest_depth = bst_pkg::NEST_W'(depth_a);

		// depth the RAM pre-read follows
		if (!in_fire) begin
			depth_n = depth_q;
		end else if (message_end) begin
			depth_n = '0;
		end else begin
			depth_n = depth_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bst_pkg::PH_EXPECT;
			accum_q  <= '0;
			neg_q    <= 1'b0;
			bytes_q  <= '0;
			depth_q  <= '0;
			top_q    <= bst_pkg::KIND_NONE;
			sticky_q <= bst_pkg::ERR_OK;
			fwd_q    <= 1'b0;
		end else begin
			fwd_q <= in_fire && push && (depth_q != '0);
			if (in_fire) begin
				if (message_end) begin
					// re-arm for the next message
					phase_q  <= bst_pkg::PH_EXPECT;
					accum_q  <= '0;
					neg_q    <= 1'b0;
					bytes_q  <= '0;
					depth_q  <= '0;
					top_q    <= bst_pkg::KIND_NONE;
					sticky_q <= bst_pkg::ERR_OK;
				end else begin
					phase_q  <= phase_n;
					accum_q  <= accum_n;
					neg_q    <= neg_n;
					bytes_q  <= bytes_n;
					depth_q  <= depth_a;
					top_q    <= top_n;
					sticky_q <= res.error_code;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= top_q;
	end

	// entries below the top; the old top is written back on each push
	bst_ram #(
		.WIDTH(KW),
		.DEPTH(MAX_DEPTH)
	) u_stack_ram (
		.clk    (clk),
		.wr_en  (in_fire && push && (depth_q != '0)),
		.wr_addr(AW'(depth_q - DW'(1))),
		.wr_data(top_q),
		.rd_addr(AW'(depth_n - DW'(2))),
		.rd_data(rd_data)
	);

	bst_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_fire),
		.push_data(res),
		.full     (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (res_out)
	);

	assign event_res  = res_out.event_res;
	assign value      = res_out.value;
	assign data_byte  = res_out.data_byte;
	assign nest_depth = res_out.nest_depth;
	assign done_res   = res_out.done_res;
	assign error_code = res_out.error_code;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("stack depth beyond limit");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && message_end |=> phase_q == bst_pkg::PH_EXPECT && depth_q == '0 &&
			sticky_q == bst_pkg::ERR_OK)
		else $error("parser not re-armed after message end");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.done_res |-> res.error_code == bst_pkg::ERR_OK &&
			phase_n == bst_pkg::PH_DONE)
		else $error("done flagged with error or incomplete value");

endmodule

>>> bench/bencode_token_checker.sv
module bencode_token_checker
	import bst_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [BYTE_W-1:0]           in_byte,
	input  logic                        message_end,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [EV_W-1:0]             event_res,
	input  logic signed [VALUE_W-1:0]   value,
	input  logic [BYTE_W-1:0]           data_byte,
	input  logic [NEST_W-1:0]           nest_depth,
	input  logic                        done_res,
	input  logic [ERR_W-1:0]            error_code,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          DEPTH_MAX = MAX_DEPTH_DEF;
	localparam logic [63:0] LEN_CAP   = (64'd1 << LEN_BITS_DEF) - 64'd1;
	localparam logic [63:0] POS_CAP   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_CAP   = 64'h8000_0000_0000_0000;

	// parser shadow state
	phase_t             phase;
	logic [63:0]        accum;
	logic               negative;
	logic [63:0]        str_left;
	logic [KIND_W-1:0]  kinds [DEPTH_MAX];
	int                 depth;
	logic [ERR_W-1:0]   sticky;

	res_t tokens_due[$];
	int   errs;

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_0 && b <= CH_9;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	// decimal multiply-accumulate, clamped at cap
	function automatic logic [63:0] sat_mac(input logic [63:0] acc, input logic [63:0] d,
			input logic [63:0] cap);
		if (acc > (cap - d) / 64'd10)
			return cap;
		return acc * 64'd10 + d;
	endfunction

	task automatic clear_parser();
		phase    = PH_EXPECT;
		accum    = '0;
		negative = 1'b0;
		str_left = '0;
		depth    = 0;
		sticky   = ERR_OK;
	endtask

	task automatic value_complete();
		if (depth == 0) begin
			phase = PH_DONE;
		end else begin
			if (kinds[depth-1] == KIND_DKEY)
				kinds[depth-1] = KIND_DVAL;
			else if (kinds[depth-1] == KIND_DVAL)
				kinds[depth-1] = KIND_DKEY;
			phase = PH_EXPECT;
		end
	endtask

	task automatic take_int_digit(input logic [7:0] b);
		accum = sat_mac(accum, 64'(b - CH_0), negative ? NEG_CAP : POS_CAP);
		phase = PH_INT_DIGITS;
	endtask

	task automatic tokenize_byte(input logic [7:0] b, input logic last, output res_t r);
		logic [EV_W-1:0]   ev;
		logic [63:0]       val;
		logic [7:0]        db;
		logic [ERR_W-1:0]  err;
		logic              done;
		logic [KIND_W-1:0] top;
		ev   = EV_NONE;
		val  = '0;
		db   = '0;
		err  = ERR_OK;
		done = 1'b0;
		if (sticky == ERR_OK) begin
			case (phase)
				PH_EXPECT: begin
					top = (depth != 0) ? kinds[depth-1] : KIND_NONE;
					if (b == CH_E && (top == KIND_LIST || top == KIND_DKEY)) begin
						depth--;
						ev = EV_CLOSE;
						value_complete();
					end else if (top == KIND_DKEY && (b == CH_I || b == CH_L || b == CH_D)) begin
						err = ERR_KEY;
					end else if (b == CH_I) begin
						accum    = '0;
						negative = 1'b0;
						phase    = PH_INT_START;
					end else if (b == CH_L || b == CH_D) begin
						if (depth >= DEPTH_MAX) begin
							err = ERR_DEEP;
						end else begin
							kinds[depth] = (b == CH_L) ? KIND_LIST : KIND_DKEY;
							depth++;
							ev = (b == CH_L) ? EV_LOPEN : EV_DOPEN;
						end
					end else if (is_digit(b)) begin
						accum = 64'(b - CH_0);
						phase = PH_STR_LEN;
					end else begin
						err = ERR_TYPE;
					end
				end
				PH_INT_START, PH_INT_WS: begin
					if (phase == PH_INT_START && b == CH_E) begin
						ev = EV_INT;
						value_complete();
					end else if (is_space(b)) begin
						phase = PH_INT_WS;
					end else if (b == CH_PLUS || b == CH_MINUS) begin
						negative = (b == CH_MINUS);
						phase    = PH_INT_SIGN;
					end else if (is_digit(b)) begin
						take_int_digit(b);
					end else begin
						err = ERR_INT_END;
					end
				end
				PH_INT_SIGN: begin
					if (is_digit(b))
						take_int_digit(b);
					else
						err = ERR_INT_END;
				end
				PH_INT_DIGITS: begin
					if (is_digit(b)) begin
						take_int_digit(b);
					end else if (b == CH_E) begin
						ev  = EV_INT;
						val = negative ? (64'd0 - accum) : accum;
						value_complete();
					end else begin
						err = ERR_INT_END;
					end
				end
				PH_STR_LEN: begin
					if (is_digit(b)) begin
						accum = sat_mac(accum, 64'(b - CH_0), LEN_CAP);
					end else if (b == CH_COLON) begin
						ev       = EV_STRHDR;
						val      = accum;
						str_left = accum;
						if (str_left == 0)
							value_complete();
						else
							phase = PH_STR_BYTES;
					end else begin
						err = ERR_COLON;
					end
				end
				PH_STR_BYTES: begin
					ev       = EV_STRBYTE;
					db       = b;
					str_left = str_left - 64'd1;
					if (str_left == 0)
						value_complete();
				end
				default: ;
			endcase
			if (err != ERR_OK) begin
				ev     = EV_NONE;
				val    = '0;
				db     = '0;
				sticky = err;
			end else if (last) begin
				if (phase == PH_DONE)
					done = 1'b1;
				else
					sticky = (phase == PH_STR_BYTES) ? ERR_OVERRUN : ERR_EARLY;
			end
		end
		r.event_res  = ev;
		r.value      = val;
		r.data_byte  = db;
		r.nest_depth = depth[NEST_W-1:0];
		r.done_res   = done;
		r.error_code = sticky;
		if (last)
			clear_parser();
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t ns: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t fresh;
		res_t want;
		if (!arst_n) begin
			clear_parser();
			tokens_due.delete();
			errs = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				tokenize_byte(in_byte, message_end, fresh);
				tokens_due.push_back(fresh);
			end
			if (out_valid && !out_stall) begin
				if (tokens_due.size() == 0) begin
					errs++;
					$display("%0t ns: result with none outstanding, event %0d error %0d",
						$time, event_res, error_code);
				end else begin
					want = tokens_due.pop_front();
					check_field("event_res", want.event_res, event_res);
					check_field("value", want.value, value);
					check_field("data_byte", want.data_byte, data_byte);
					check_field("nest_depth", want.nest_depth, nest_depth);
					check_field("done_res", want.done_res, done_res);
					check_field("error_code", want.error_code, error_code);
				end
			end
			fail_count <= errs;
			pending    <= tokens_due.size();
		end
	end

endmodule

>>> bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bst_pkg::*;

	// cycles without a single transaction on either side before we give up
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [BYTE_W-1:0]          in_byte = '0;
	logic                       message_end = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [EV_W-1:0]            event_res;
	logic signed [VALUE_W-1:0]  value;
	logic [BYTE_W-1:0]          data_byte;
	logic [NEST_W-1:0]          nest_depth;
	logic                       done_res;
	logic [ERR_W-1:0]           error_code;

	int fail_count;
	int pending;

	// idle rates, in percent, for the current phase
	int in_gap_pct;
	int out_stall_pct;

	// message under construction, and running byte count
	logic [7:0] msg_q[$];
	int         bytes_sent;
	int         quiet_cycles;

	bencode_stream_tokenizer_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.message_end(message_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.value      (value),
		.data_byte  (data_byte),
		.nest_depth (nest_depth),
		.done_res   (done_res),
		.error_code (error_code)
	);

	bencode_token_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.message_end(message_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.value      (value),
		.data_byte  (data_byte),
		.nest_depth (nest_depth),
		.done_res   (done_res),
		.error_code (error_code),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver back-pressure: redrawn every falling edge, stall may drop or rise freely.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < out_stall_pct);
	end

	// Watchdog: a hung handshake shows up as a long run of cycles with no transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	// One input transaction. Entered at a falling edge, returns at a falling edge.
	// Gaps lower valid for whole cycles; valid is never dropped and raised in one step.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		message_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Push the buffer out, message_end on its final byte.
	task automatic send_message();
		for (int i = 0; i < msg_q.size(); i++)
			send_byte(msg_q[i], i == msg_q.size() - 1);
		bytes_sent += msg_q.size();
		msg_q.delete();
	endtask

	task automatic put(input logic [7:0] b);
		msg_q.push_back(b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_digits(input int n);
		repeat (n) put(8'(CH_0 + $urandom_range(0, 9)));
	endtask

	// Length-prefixed string; mostly short, now and then with a leading zero.
	task automatic gen_string();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
		if ($urandom_range(0, 9) == 0)
			put(CH_0);
		put_text($sformatf("%0d", n));
		put(CH_COLON);
		repeat (n) put(8'($urandom_range(0, 255)));
	endtask

	// Integer with optional whitespace and sign. Long digit runs can push the value
	// into saturation at either signed limit; no digits at all gives "ie", or
	// a bad int end when whitespace or a sign came first.
	task automatic gen_int();
		int r;
		int nd;
		put(CH_I);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				r = $urandom_range(0, 5);
				put((r == 0) ? CH_SPACE : 8'(8 + r));
			end
		end
		r = $urandom_range(0, 3);
		if (r == 0)
			put(CH_PLUS);
		else if (r == 1)
			put(CH_MINUS);
		r = $urandom_range(0, 9);
		if (r == 0) begin
			nd = 0;
		end else if (r < 8) begin
			nd = $urandom_range(1, 3);
		end else begin
			put(CH_9);
			nd = $urandom_range(17, 20);
		end
		put_digits(nd);
		put(CH_E);
	endtask

	// Any value, nesting capped at three levels. Dictionary keys are strings,
	// bar the odd integer to provoke the key-not-string error.
	task automatic gen_value(input int lvl, input bit as_key);
		int kind;
		int n;
		if (as_key) begin
			if ($urandom_range(0, 19) == 0)
				gen_int();
			else
				gen_string();
			return;
		end
		kind = (lvl >= 3) ? $urandom_range(0, 1) : $urandom_range(0, 3);
		n    = $urandom_range(0, 3);
		case (kind)
			0: gen_int();
			1: gen_string();
			2: begin
				put(CH_L);
				repeat (n) gen_value(lvl + 1, 1'b0);
				put(CH_E);
			end
			default: begin
				put(CH_D);
				repeat (n) begin
					gen_value(lvl + 1, 1'b1);
					gen_value(lvl + 1, 1'b0);
				end
				put(CH_E);
			end
		endcase
	endtask

	// Chain of containers close to, at or one past the stack limit.
	task automatic gen_deep_chain();
		int n;
		n = $urandom_range(MAX_DEPTH_DEF - 4, MAX_DEPTH_DEF + 1);
		repeat (n) begin
			if ($urandom_range(0, 1)) begin
				put(CH_L);
			end else begin
				put(CH_D);
				put_text("1:");
				put(8'($urandom_range(0, 255)));
			end
		end
		gen_value(3, 1'b0);
		repeat (n) put(CH_E);
	endtask

	// Mostly well-formed messages; the rest trailing junk, truncation, a single
	// corrupted byte, deep nesting, oversized lengths and plain noise.
	task automatic make_message();
		int         r;
		int         cut;
		logic [7:0] junk;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			gen_value(0, 1'b0);
		end else if (r < 70) begin
			gen_value(0, 1'b0);
			repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
		end else if (r < 80) begin
			gen_value(0, 1'b0);
			cut = $urandom_range(1, msg_q.size() - 1);
			while (msg_q.size() > cut)
				junk = msg_q.pop_back();
		end else if (r < 87) begin
			gen_value(0, 1'b0);
			msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (r < 92) begin
			gen_deep_chain();
		end else if (r < 96) begin
			// length beyond the counter width: saturates, and the message ends in the data
			put(CH_9);
			put_digits($urandom_range(9, 12));
			put(CH_COLON);
			repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random(input int budget);
		int goal;
		goal = bytes_sent + budget;
		while (bytes_sent < goal) begin
			make_message();
			send_message();
		end
	endtask

	// Short hand-picked messages, one per special case.
	task automatic run_directed();
		put_text("ie");      send_message();   // empty integer reads as zero
		put_text("i-e");     send_message();   // sign with no digits
		put_text("2:ab");    send_message();   // string closing on the last byte
		put_text("3:ab");    send_message();   // buffer ends inside string data
		put_text("di1ee");   send_message();   // integer where a key is due
		put_text("d1:ae");   send_message();   // close where a dict value is due
		put_text("e");       send_message();   // close at top level
		put_text("l");       send_message();   // ends inside a container
		put_text("1x");      send_message();   // length without colon
		put_text("le");
		put(8'hff);
		put(8'h00);
		send_message();                       // trailing bytes after the value
	endtask

	initial begin
		in_gap_pct    = 13;
		out_stall_pct = 54;
		bytes_sent    = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Phase one: light sender gaps, heavy receiver stall.
		run_directed();
		run_random(217);

		// Phase two: the other way round.
		in_gap_pct    = 54;
		out_stall_pct = 13;
		run_random(217);

		// Phase three: flat out on both sides.
		in_gap_pct    = 0;
		out_stall_pct = 0;
		run_random(216);

		in_valid <= 1'b0;

		// drain; the watchdog catches a result that never turns up
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
